>>> rtl/core/cesd_pkg.sv
`default_nettype none
package cesd_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_BSLASH = 3'd1,
    MODE_OCT    = 3'd2,
    MODE_HEX    = 3'd3,
    MODE_DROP   = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    ST_BYTE     = 2'd0,
    ST_END      = 2'd1,
    ST_UNKNOWN  = 2'd2,
    ST_DANGLING = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] out_byte;
    status_t    status;
    logic       last_result;
  } res_t;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_X_LO   = 8'h78;
  localparam logic [7:0] CH_X_UP   = 8'h58;

  localparam int unsigned MAX_RES = 3;

  function automatic logic is_octal(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h37);
  endfunction

  // {valid, digit value}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
      return {1'b1, d[3:0]};
    end
    if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h57;
      return {1'b1, d[3:0]};
    end
    if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h37;
      return {1'b1, d[3:0]};
    end
    return 5'd0;
  endfunction

  // {hit, decoded byte} for the named escapes
  function automatic logic [8:0] named_escape(input logic [7:0] c);
    logic [8:0] r;
    unique case (c)
      8'h6E:   r = {1'b1, 8'h0A};  // n
      8'h74:   r = {1'b1, 8'h09};  // t
      8'h76:   r = {1'b1, 8'h0B};  // v
      8'h62:   r = {1'b1, 8'h08};  // b
      8'h72:   r = {1'b1, 8'h0D};  // r
      8'h66:   r = {1'b1, 8'h0C};  // f
      8'h61:   r = {1'b1, 8'h07};  // a
      8'h5C:   r = {1'b1, 8'h5C};
      8'h22:   r = {1'b1, 8'h22};
      8'h27:   r = {1'b1, 8'h27};
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/cesd_if.sv
`default_nettype none
interface cesd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_of_string;

  modport source (output valid, in_byte, last_of_string, input ready);
  modport sink   (input valid, in_byte, last_of_string, output ready);
endinterface

interface cesd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] status;
  logic       last_result;

  modport source (output valid, out_byte, status, last_result, input ready);
  modport sink   (input valid, out_byte, status, last_result, output ready);
endinterface
`default_nettype wire

>>> rtl/core/c_string_escape_decoder_top.sv
// Channel   Dir  Payload                              Handshake
// in_ch     in   in_byte[7:0], last_of_string         valid/ready
// out_ch    out  out_byte[7:0], status[1:0],          valid/ready
//                last_result
//
// One input byte per cycle while out_ch.ready is high and no byte gives more
// than one result. A byte gives 0 to 3 results; the result buffer drains one
// per cycle while ready and holds the decode stage until its last is taken.
// An input register lets a byte be taken while results still wait.
// rst_n is synchronous, active low; it returns the decoder to idle.
`default_nettype none
module c_string_escape_decoder_top
  import cesd_pkg::*;
(
  input  wire              clk,
  input  wire              rst_n,
  cesd_in_if.sink          in_ch,
  cesd_out_if.source       out_ch
);

  logic       ivld_r;
  logic [7:0] ibyte_r;
  logic       ilast_r;

  mode_t      mode_r, mode_nxt;
  logic [8:0] val_r, val_nxt;
  logic [1:0] dig_r, dig_nxt;

  res_t       res_r [MAX_RES];
  logic [1:0] ocnt_r, ocnt_nxt;

  res_t       res_d [MAX_RES];
  logic [1:0] dec_n;

  logic pop, adv, in_xfer;

  assign pop     = (ocnt_r != 2'd0) && out_ch.ready;
  assign adv     = ivld_r && ((ocnt_r == 2'd0) || ((ocnt_r == 2'd1) && out_ch.ready));
  assign in_ch.ready = !ivld_r || adv;
  assign in_xfer = in_ch.valid && in_ch.ready;

  assign out_ch.valid       = (ocnt_r != 2'd0);
  assign out_ch.out_byte    = res_r[0].out_byte;
  assign out_ch.status      = res_r[0].status;
  assign out_ch.last_result = res_r[0].last_result;

  // decode helpers
  logic       c_bs, c_oct, c_x, hex_ok, oct_ok;
  logic [4:0] hx;
  logic [8:0] nm;
  logic [8:0] oct_v, hex_v;

  always_comb begin
    c_bs   = (ibyte_r == CH_BSLASH);
    c_oct  = is_octal(ibyte_r);
    c_x    = (ibyte_r == CH_X_LO) || (ibyte_r == CH_X_UP);
    hx     = hex_digit(ibyte_r);
    nm     = named_escape(ibyte_r);
    oct_ok = c_oct && (dig_r != 2'd3);
    hex_ok = hx[4] && (dig_r < 2'd2);
    oct_v  = {val_r[5:0], ibyte_r[2:0]};
    hex_v  = {val_r[4:0], hx[3:0]};
  end

  // next state
  always_comb begin
    mode_nxt = mode_r;
    val_nxt  = val_r;
    dig_nxt  = dig_r;
    unique case (mode_r)
      MODE_BSLASH: begin
        if (c_oct) begin
          val_nxt  = {6'd0, ibyte_r[2:0]};
          dig_nxt  = 2'd1;
          mode_nxt = MODE_OCT;
          if (ilast_r) begin
            val_nxt  = 9'd0;
            dig_nxt  = 2'd0;
            mode_nxt = MODE_IDLE;
          end
        end else if (c_x) begin
          val_nxt  = 9'd0;
          dig_nxt  = 2'd0;
          mode_nxt = ilast_r ? MODE_IDLE : MODE_HEX;
        end else if (nm[8]) begin
          mode_nxt = MODE_IDLE;
        end else begin
          mode_nxt = ilast_r ? MODE_IDLE : MODE_DROP;
        end
      end
      MODE_OCT, MODE_HEX: begin
        if ((mode_r == MODE_OCT) ? oct_ok : hex_ok) begin
          val_nxt = (mode_r == MODE_OCT) ? oct_v : hex_v;
          dig_nxt = dig_r + 2'd1;
          if (ilast_r || ((mode_r == MODE_OCT) ? (dig_r == 2'd2) : (dig_r == 2'd1))) begin
            val_nxt  = 9'd0;
            dig_nxt  = 2'd0;
            mode_nxt = MODE_IDLE;
          end
        end else begin
          val_nxt  = 9'd0;
          dig_nxt  = 2'd0;
          mode_nxt = (c_bs && !ilast_r) ? MODE_BSLASH : MODE_IDLE;
        end
      end
      MODE_DROP: begin
        if (ilast_r) mode_nxt = MODE_IDLE;
      end
      default: begin
        mode_nxt = (c_bs && !ilast_r) ? MODE_BSLASH : MODE_IDLE;
      end
    endcase
  end

  // results: pending value, main result, end marker
  logic       pre_en, main_en, end_en;
  logic [7:0] pre_byte, main_byte;
  status_t    main_st;
  logic [1:0] idx;

  always_comb begin
    pre_en    = 1'b0;
    pre_byte  = 8'd0;
    main_en   = 1'b0;
    main_byte = 8'd0;
    main_st   = ST_BYTE;
    end_en    = 1'b0;
    unique case (mode_r)
      MODE_BSLASH: begin
        if (c_oct) begin
          main_en   = ilast_r;
          main_byte = {5'd0, ibyte_r[2:0]};
          end_en    = ilast_r;
        end else if (c_x) begin
          main_en = ilast_r;
          end_en  = ilast_r;
        end else if (nm[8]) begin
          main_en   = 1'b1;
          main_byte = nm[7:0];
          end_en    = ilast_r;
        end else begin
          main_en = 1'b1;
          main_st = ST_UNKNOWN;
        end
      end
      MODE_OCT, MODE_HEX: begin
        if ((mode_r == MODE_OCT) ? oct_ok : hex_ok) begin
          main_en   = ilast_r ||
                      ((mode_r == MODE_OCT) ? (dig_r == 2'd2) : (dig_r == 2'd1));
          main_byte = (mode_r == MODE_OCT) ? oct_v[7:0] : hex_v[7:0];
          end_en    = ilast_r;
        end else begin
          pre_en   = 1'b1;
          pre_byte = val_r[7:0];
          if (c_bs) begin
            main_en = ilast_r;
            main_st = ST_DANGLING;
          end else begin
            main_en   = 1'b1;
            main_byte = ibyte_r;
            end_en    = ilast_r;
          end
        end
      end
      MODE_DROP: begin
        main_en = 1'b0;
      end
      default: begin
        if (c_bs) begin
          main_en = ilast_r;
          main_st = ST_DANGLING;
        end else begin
          main_en   = 1'b1;
          main_byte = ibyte_r;
          end_en    = ilast_r;
        end
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < MAX_RES; i++) begin
      res_d[i] = '0;
    end
    idx = 2'd0;
    if (pre_en) begin
      res_d[idx] = '{out_byte: pre_byte, status: ST_BYTE, last_result: 1'b0};
      idx = idx + 2'd1;
    end
    if (main_en) begin
      res_d[idx] = '{out_byte: (main_st == ST_BYTE) ? main_byte : 8'd0,
                     status: main_st, last_result: 1'b0};
      idx = idx + 2'd1;
    end
    if (end_en) begin
      res_d[idx] = '{out_byte: 8'd0, status: ST_END, last_result: 1'b0};
      idx = idx + 2'd1;
    end
    dec_n = idx;
    if (idx != 2'd0) begin
      res_d[idx - 2'd1].last_result = 1'b1;
    end
  end

  always_comb begin
    ocnt_nxt = ocnt_r;
    if (adv) begin
      ocnt_nxt = dec_n;
    end else if (pop) begin
      ocnt_nxt = ocnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ivld_r <= 1'b0;
      mode_r <= MODE_IDLE;
      val_r  <= 9'd0;
      dig_r  <= 2'd0;
      ocnt_r <= 2'd0;
    end else begin
      if (in_xfer) begin
        ivld_r <= 1'b1;
      end else if (adv) begin
        ivld_r <= 1'b0;
      end
      if (adv) begin
        mode_r <= mode_nxt;
        val_r  <= val_nxt;
        dig_r  <= dig_nxt;
      end
      ocnt_r <= ocnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      ibyte_r <= in_ch.in_byte;
      ilast_r <= in_ch.last_of_string;
    end
    if (adv) begin
      for (int i = 0; i < MAX_RES; i++) begin
        res_r[i] <= res_d[i];
      end
    end else if (pop) begin
      res_r[0] <= res_r[1];
      res_r[1] <= res_r[2];
    end
  end

`ifndef SYNTHESIS
  a_single_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (ocnt_r == 2'd1) |-> res_r[0].last_result)
    else $error("single pending result not marked last");

  a_status_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.status != ST_BYTE)) |-> (out_ch.out_byte == 8'd0))
    else $error("non-byte result carries data");

  a_oct_digits: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_OCT) |-> ((dig_r == 2'd1) || (dig_r == 2'd2)))
    else $error("octal digit count out of range");

  a_hex_digits: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_HEX) |-> ((dig_r == 2'd0) || (dig_r == 2'd1)))
    else $error("hex digit count out of range");

  a_stall_means_held: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (ivld_r && (ocnt_r != 2'd0)))
    else $error("input stalled with nothing pending");
`endif

endmodule
`default_nettype wire

>>> tb/tb_c_string_escape_decoder_top.sv
`timescale 1ns / 1ps
module tb_c_string_escape_decoder_top;
  import cesd_pkg::*;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
  } str_byte_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic [7:0] in_byte = 8'h00;
  logic       in_last = 1'b0;
  logic       out_ready = 1'b0;

  cesd_in_if  in_ch();
  cesd_out_if out_ch();

  assign in_ch.valid          = in_valid;
  assign in_ch.in_byte        = in_byte;
  assign in_ch.last_of_string = in_last;
  assign out_ch.ready         = out_ready;

  c_string_escape_decoder_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  str_byte_t  pending_bytes[$];
  logic [7:0] build_q[$];
  res_t       expected_results[$];
  res_t       step_results[$];

  mode_t      dec_mode = MODE_IDLE;
  logic [8:0] esc_val = '0;
  logic [1:0] n_digits = '0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit in_taken = 1'b0;
  int errors = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  // ---------------- decoder prediction ----------------

  function automatic void add_result(input logic [7:0] b, input status_t st);
    res_t r;
    r.out_byte    = (st == ST_BYTE) ? b : 8'h00;
    r.status      = st;
    r.last_result = 1'b0;
    if (step_results.size() < MAX_RES) step_results.push_back(r);
  endfunction

  function automatic void flush_value();
    add_result(esc_val[7:0], ST_BYTE);
    dec_mode = MODE_IDLE;
    esc_val  = '0;
    n_digits = '0;
  endfunction

  function automatic void fresh_byte(input logic [7:0] c, input logic last);
    if (c == CH_BSLASH) begin
      if (last) add_result(8'h00, ST_DANGLING);
      dec_mode = last ? MODE_IDLE : MODE_BSLASH;
    end else begin
      dec_mode = MODE_IDLE;
      add_result(c, ST_BYTE);
      if (last) add_result(8'h00, ST_END);
    end
  endfunction

  function automatic void decode_byte(input logic [7:0] c, input logic last);
    logic       is_oct;
    logic       is_hex;
    logic [3:0] hval;
    logic       named_hit;
    logic [7:0] named_val;
    res_t       r;
    is_oct = (c >= "0") && (c <= "7");
    is_hex = ((c >= "0") && (c <= "9")) || ((c >= "a") && (c <= "f")) ||
             ((c >= "A") && (c <= "F"));
    hval   = ((c >= "0") && (c <= "9")) ? c[3:0] : c[3:0] + 4'd9;
    named_hit = 1'b1;
    case (c)
      "n":     named_val = 8'h0A;
      "t":     named_val = 8'h09;
      "v":     named_val = 8'h0B;
      "b":     named_val = 8'h08;
      "r":     named_val = 8'h0D;
      "f":     named_val = 8'h0C;
      "a":     named_val = 8'h07;
      "\\":    named_val = 8'h5C;
      "\"":    named_val = 8'h22;
      "'":     named_val = 8'h27;
      default: begin
        named_val = 8'h00;
        named_hit = 1'b0;
      end
    endcase
    step_results.delete();
    case (dec_mode)
      MODE_BSLASH: begin
        if (is_oct) begin
          esc_val  = {6'd0, c[2:0]};
          n_digits = 2'd1;
          dec_mode = MODE_OCT;
          if (last) begin
            flush_value();
            add_result(8'h00, ST_END);
          end
        end else if (c == CH_X_LO || c == CH_X_UP) begin
          esc_val  = '0;
          n_digits = '0;
          dec_mode = MODE_HEX;
          if (last) begin
            flush_value();
            add_result(8'h00, ST_END);
          end
        end else if (named_hit) begin
          dec_mode = MODE_IDLE;
          add_result(named_val, ST_BYTE);
          if (last) add_result(8'h00, ST_END);
        end else begin
          add_result(8'h00, ST_UNKNOWN);
          dec_mode = last ? MODE_IDLE : MODE_DROP;
        end
      end
      MODE_OCT: begin
        if (is_oct && n_digits < 2'd3) begin
          esc_val  = {esc_val[5:0], c[2:0]};
          n_digits = n_digits + 2'd1;
          if (n_digits == 2'd3 || last) flush_value();
          if (last) begin
            add_result(8'h00, ST_END);
            dec_mode = MODE_IDLE;
          end
        end else begin
          flush_value();
          fresh_byte(c, last);
        end
      end
      MODE_HEX: begin
        if (is_hex && n_digits < 2'd2) begin
          esc_val  = {esc_val[4:0], hval};
          n_digits = n_digits + 2'd1;
          if (n_digits == 2'd2 || last) flush_value();
          if (last) begin
            add_result(8'h00, ST_END);
            dec_mode = MODE_IDLE;
          end
        end else begin
          flush_value();
          fresh_byte(c, last);
        end
      end
      MODE_DROP: begin
        if (last) dec_mode = MODE_IDLE;
      end
      default: fresh_byte(c, last);
    endcase
    if (step_results.size() != 0) begin
      r = step_results.pop_back();
      r.last_result = 1'b1;
      step_results.push_back(r);
    end
    foreach (step_results[i]) expected_results.push_back(step_results[i]);
  endfunction

  // ---------------- string building ----------------

  function automatic logic [7:0] named_letter(input int i);
    case (i)
      0:       return "n";
      1:       return "t";
      2:       return "v";
      3:       return "b";
      4:       return "r";
      5:       return "f";
      6:       return "a";
      7:       return "\\";
      8:       return "\"";
      default: return "'";
    endcase
  endfunction

  function automatic logic [7:0] hex_char(input int i);
    if (i < 10) return 8'h30 + 8'(i);
    if (i < 16) return 8'h61 + 8'(i - 10);
    return 8'h41 + 8'(i - 16);
  endfunction

  task automatic close_string();
    str_byte_t sb;
    foreach (build_q[i]) begin
      sb.b    = build_q[i];
      sb.last = (i == build_q.size() - 1);
      pending_bytes.push_back(sb);
    end
    build_q.delete();
  endtask

  task automatic push_string(input string s);
    for (int i = 0; i < s.len(); i++) build_q.push_back(s[i]);
    close_string();
  endtask

  // mostly well-formed escapes with random content, some noise
  task automatic add_random_string();
    int pieces;
    int kind;
    int k;
    pieces = $urandom_range(8, 1);
    for (int p = 0; p < pieces; p++) begin
      kind = $urandom_range(99);
      if (kind < 30) begin
        build_q.push_back(8'($urandom_range(255)));
      end else begin
        build_q.push_back(CH_BSLASH);
        if (kind < 50) begin
          build_q.push_back(named_letter($urandom_range(9)));
        end else if (kind < 70) begin
          k = $urandom_range(3, 1);
          repeat (k) build_q.push_back(8'h30 + 8'($urandom_range(7)));
        end else if (kind < 88) begin
          build_q.push_back($urandom_range(1) ? CH_X_UP : CH_X_LO);
          k = $urandom_range(2);
          repeat (k) build_q.push_back(hex_char($urandom_range(21)));
        end else if (kind < 94) begin
          case ($urandom_range(5))
            0:       build_q.push_back("q");
            1:       build_q.push_back("9");
            2:       build_q.push_back("Z");
            3:       build_q.push_back(8'hFF);
            4:       build_q.push_back(8'h00);
            default: build_q.push_back("e");
          endcase
        end
      end
    end
    close_string();
  endtask

  // ---------------- driver and monitor ----------------

  always @(negedge clk) begin
    str_byte_t nb;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nb = pending_bytes.pop_front();
        in_valid <= 1'b1;
        in_byte  <= nb.b;
        in_last  <= nb.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
    in_taken = 1'b0;
    out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    res_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        decode_byte(in_ch.in_byte, in_ch.last_of_string);
        in_taken = 1'b1;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected transfer: out_byte %0h status %0d last_result %0b",
                 out_ch.out_byte, out_ch.status, out_ch.last_result);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (out_ch.out_byte !== want.out_byte) begin
            $error("out_byte: expected %0h, actual %0h", want.out_byte, out_ch.out_byte);
            errors++;
          end
          if (out_ch.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_ch.status);
            errors++;
          end
          if (out_ch.last_result !== want.last_result) begin
            $error("last_result: expected %0b, actual %0b",
                   want.last_result, out_ch.last_result);
            errors++;
          end
        end
      end
    end
  end

  // ---------------- sequence ----------------

  initial begin
    int target;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 64 : 0;
      recv_idle_pct = (phase == 0) ? 64 : (phase == 1) ? 24 : 0;
      if (phase == 0) begin
        build_q.push_back(8'h00);
        build_q.push_back(8'hFF);
        close_string();
        push_string("\\777");
        push_string("\\x");
        push_string("\\x4g");
        push_string("\\qz");
        push_string("\\z");
        push_string("\\");
        push_string("\\1\\n");
        push_string("\\xFf");
      end
      target = pending_bytes.size() + 112;
      while (pending_bytes.size() < target) add_random_string();
      while (pending_bytes.size() != 0 || in_valid) @(posedge clk);
    end

    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("c_string_escape_decoder_top: match");
    end else begin
      $display("c_string_escape_decoder_top: mismatch");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("c_string_escape_decoder_top: mismatch");
    $finish;
  end

endmodule
